// File: rtl/core/vru_pkg.sv
package vru_pkg;

    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int TOTAL_W     = 24;
    localparam int OP_W        = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_CNT_W   = $clog2(ACC_W);
    localparam int PROD_SHIFT  = 16;

    // Q16.16 limits as 32-bit words and sign-extended to ACC_W; then ACC limits
    localparam logic [DATA_W-1:0] Q32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q32_MIN = 32'h8000_0000;
    localparam logic [ACC_W-1:0]  Q64_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [ACC_W-1:0]  Q64_MIN = 64'hFFFF_FFFF_8000_0000;
    localparam logic [ACC_W-1:0]  ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0]  ACC_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_MAX  = 3'd0,
        OP_MIN  = 3'd1,
        OP_SUM  = 3'd2,
        OP_PROD = 3'd3,
        OP_MEAN = 3'd4
    } op_t;

    localparam logic [OP_W-1:0] OP_RESET = OP_SUM;

    // One classified element on its way from front to back
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        op_t                      op;
    } cmd_t;

endpackage

// File: rtl/core/vru_front.sv
module vru_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vru_pkg::OP_W-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [vru_pkg::DATA_W-1:0] element_value,
    input  logic                          last_of_group,
    input  logic                          q_full,
    output logic                          q_push,
    output vru_pkg::cmd_t                 q_cmd
);
    import vru_pkg::*;

    logic [OP_W-1:0] op_raw_reg;
    op_t             op_class;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_raw_reg <= OP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            op_raw_reg <= cfg_data;
        end
    end

    // unused codes behave as sum
    always_comb
    begin
        case (op_raw_reg) inside
            OP_MAX, OP_MIN, OP_SUM, OP_PROD, OP_MEAN: op_class = op_t'(op_raw_reg);
            default:                                  op_class = OP_SUM;
        endcase
    end

    assign in_ready     = !q_full;
    assign q_push       = in_valid && in_ready;
    assign q_cmd.value  = element_value;
    assign q_cmd.last   = last_of_group;
    assign q_cmd.op     = op_class;

endmodule

// File: rtl/core/vru_queue.sv
module vru_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vru_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output vru_pkg::cmd_t pop_cmd
);
    import vru_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;

    assign valid   = (fill_reg != '0);
    assign full    = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// File: rtl/core/vru_back.sv
module vru_back #(
    parameter int COUNT_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  vru_pkg::cmd_t                     q_cmd,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [vru_pkg::DATA_W-1:0] reduced_value,
    output logic [vru_pkg::TOTAL_W-1:0]       element_total,
    output logic                              saturated
);
    import vru_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DPREP,
        S_DIV,
        S_FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    first_reg, first_next;
    logic                    clamp_reg, clamp_next;
    logic                    last_reg, last_next;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic                    pclamp_reg, pclamp_next;
    logic [ACC_W-1:0]        quo_reg, quo_next;
    logic [COUNT_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]    dcnt_reg, dcnt_next;
    logic                    dneg_reg, dneg_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]       out_value_reg, out_value_next;
    logic [TOTAL_W-1:0]      out_total_reg, out_total_next;
    logic                    out_sat_reg, out_sat_next;

    logic signed [ACC_W-1:0]  x64;
    logic                     a_fits;
    logic [DATA_W-1:0]        a32;
    logic signed [ACC_W-1:0]  mul_full;
    logic [ACC_W:0]           sum65;
    logic                     sum_ovf;
    logic signed [ACC_W-1:0]  shifted;
    logic                     s_fits;
    logic [COUNT_BITS-1:0]    count_inc;
    logic [COUNT_BITS:0]      trial;
    logic [COUNT_BITS:0]      diff;
    logic                     ge;
    logic [ACC_W-1:0]         quo_step;
    logic                     f_fits;
    logic [DATA_W-1:0]        fval;
    logic                     close_mean;

    assign x64       = {{(ACC_W-DATA_W){q_cmd.value[DATA_W-1]}}, q_cmd.value};

    // product operand: accumulator clamped to Q16.16 first
    assign a_fits    = (&acc_reg[ACC_W-1:DATA_W-1]) || !(|acc_reg[ACC_W-1:DATA_W-1]);
    assign a32       = a_fits ? acc_reg[DATA_W-1:0] : (acc_reg[ACC_W-1] ? Q32_MIN : Q32_MAX);
    assign mul_full  = $signed(a32) * q_cmd.value;

    assign sum65     = {acc_reg[ACC_W-1], acc_reg} + {x64[ACC_W-1], x64};
    assign sum_ovf   = (sum65[ACC_W] != sum65[ACC_W-1]);

    // arithmetic shift is floor rounding
    assign shifted   = prod_reg >>> PROD_SHIFT;
    assign s_fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;

    // restoring division, one quotient bit per cycle
    assign trial     = {rem_reg, quo_reg[ACC_W-1]};
    assign ge        = (trial >= {1'b0, count_reg});
    assign diff      = trial - {1'b0, count_reg};
    assign quo_step  = {quo_reg[ACC_W-2:0], ge};

    assign f_fits    = (&acc_reg[ACC_W-1:DATA_W-1]) || !(|acc_reg[ACC_W-1:DATA_W-1]);
    assign fval      = f_fits ? acc_reg[DATA_W-1:0] : (acc_reg[ACC_W-1] ? Q32_MIN : Q32_MAX);

    assign close_mean = (q_cmd.op == OP_MEAN);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        clamp_next     = clamp_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        pclamp_next    = pclamp_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        dneg_next      = dneg_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_total_next = out_total_reg;
        out_sat_next   = out_sat_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    last_next = q_cmd.last;
                    if (first_reg)
                    begin
                        acc_next   = x64;
                        count_next = COUNT_BITS'(1);
                        clamp_next = 1'b0;
                        first_next = 1'b0;
                        if (q_cmd.last)
                        begin
                            state_next = close_mean ? S_DPREP : S_FIN;
                        end
                    end
                    else
                    begin
                        count_next = count_inc;
                        case (q_cmd.op)
                            OP_MAX:
                            begin
                                if (x64 > acc_reg)
                                begin
                                    acc_next = x64;
                                end
                            end
                            OP_MIN:
                            begin
                                if (x64 < acc_reg)
                                begin
                                    acc_next = x64;
                                end
                            end
                            OP_PROD:
                            begin
                                prod_next   = mul_full;
                                pclamp_next = !a_fits;
                            end
                            default:
                            begin
                                if (sum_ovf)
                                begin
                                    acc_next   = sum65[ACC_W] ? ACC_MIN : ACC_MAX;
                                    clamp_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = sum65[ACC_W-1:0];
                                end
                            end
                        endcase
                        if (q_cmd.op == OP_PROD)
                        begin
                            state_next = S_MUL;
                        end
                        else if (q_cmd.last)
                        begin
                            state_next = close_mean ? S_DPREP : S_FIN;
                        end
                    end
                end
            end
            S_MUL:
            begin
                acc_next   = s_fits ? shifted : (shifted[ACC_W-1] ? Q64_MIN : Q64_MAX);
                clamp_next = clamp_reg || pclamp_reg || !s_fits;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_DPREP:
            begin
                dneg_next  = acc_reg[ACC_W-1];
                quo_next   = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                quo_next  = quo_step;
                dcnt_next = dcnt_reg + 1'b1;
                if (&dcnt_reg)
                begin
                    acc_next   = dneg_reg ? -quo_step : quo_step;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = fval;
                    out_total_next = TOTAL_W'(count_reg);
                    out_sat_next   = clamp_reg || !f_fits;
                    acc_next       = '0;
                    count_next     = '0;
                    clamp_next     = 1'b0;
                    first_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            count_reg     <= '0;
            first_reg     <= 1'b1;
            clamp_reg     <= 1'b0;
            last_reg      <= 1'b0;
            prod_reg      <= '0;
            pclamp_reg    <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            dcnt_reg      <= '0;
            dneg_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_total_reg <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            clamp_reg     <= clamp_next;
            last_reg      <= last_next;
            prod_reg      <= prod_next;
            pclamp_reg    <= pclamp_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            dcnt_reg      <= dcnt_next;
            dneg_reg      <= dneg_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_total_reg <= out_total_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reduced_value = out_value_reg;
    assign element_total = out_total_reg;
    assign saturated     = out_sat_reg;

endmodule

// File: rtl/core/vector_reduction_unit_top.sv
// Streaming reduction of signed Q16.16 elements (max, min, sum, product or
// mean per group, chosen by the 3-bit operation register; codes 5..7 act as
// sum). Each transaction on the input channel carries one element and a
// last-of-group mark; each group yields one output transaction with the
// saturated result, the element count (low 24 bits) and a saturation flag.
// The front end accepts elements into a 4-entry queue whenever it has room,
// so input transactions keep flowing while the back end works or while a
// result waits in the output register. The back end retires one element per
// cycle for max, min, sum and mean; each product element after the first
// takes a registered 32x32 multiply, then shift and clamp. A closed group
// enters the output register once any older result is taken; a mean group
// first runs S_DPREP and the 64-step restoring divider (one quotient bit
// per cycle). Write the operation register only while the block is idle; it
// applies to every element accepted afterwards. COUNT_BITS sets the element
// counter width (8..32); the counter saturates at its maximum.
module vector_reduction_unit_top #(
    parameter int COUNT_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vru_pkg::OP_W-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [vru_pkg::DATA_W-1:0] element_value,
    input  logic                              last_of_group,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [vru_pkg::DATA_W-1:0] reduced_value,
    output logic [vru_pkg::TOTAL_W-1:0]       element_total,
    output logic                              saturated
);
    import vru_pkg::*;

    // front -> queue
    logic q_push;
    logic q_full;
    cmd_t push_cmd;

    // queue -> back
    logic q_pop;
    logic q_valid;
    cmd_t pop_cmd;

    // operation register, op classification and input handshake
    vru_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .last_of_group (last_of_group),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    // decouples input acceptance from back-end stalls
    vru_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    // accumulator, multiplier, divider and output register
    vru_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reduced_value (reduced_value),
        .element_total (element_total),
        .saturated     (saturated)
    );

endmodule

// File: test/vector_reduction_unit_checker.sv
`timescale 1ns / 1ps

module vector_reduction_unit_checker #(
    parameter int COUNT_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [vru_pkg::OP_W-1:0]          cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [vru_pkg::DATA_W-1:0] element_value,
    input  logic                              last_of_group,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [vru_pkg::DATA_W-1:0] reduced_value,
    input  logic [vru_pkg::TOTAL_W-1:0]       element_total,
    input  logic                              saturated,
    output int                                mismatches,
    output int                                outstanding
);
    import vru_pkg::*;

    localparam logic signed [ACC_W-1:0] Q_HI = Q64_MAX;
    localparam logic signed [ACC_W-1:0] Q_LO = Q64_MIN;
    localparam logic [31:0] COUNT_CEIL = 32'((64'd1 << COUNT_BITS) - 64'd1);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [TOTAL_W-1:0]       total;
        logic                     sat;
    } group_result_t;

    group_result_t           pending_results[$];
    group_result_t           oldest;
    logic [OP_W-1:0]         op_setting;
    logic signed [ACC_W-1:0] running_acc;
    logic [31:0]             group_count;
    logic                    opening;
    logic                    clamped;
    int                      errors = 0;

    function automatic bit out_of_q16(input logic signed [ACC_W-1:0] v);
        return (v > Q_HI) || (v < Q_LO);
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp_q16(input logic signed [ACC_W-1:0] v);
        if (v > Q_HI)
        begin
            return Q_HI;
        end
        if (v < Q_LO)
        begin
            return Q_LO;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // Folds one accepted element into the running group; queues a result on close.
    task automatic reduce_element(input logic signed [DATA_W-1:0] x, input logic closes);
        logic signed [ACC_W-1:0] xw;
        logic signed [ACC_W-1:0] factor;
        logic signed [ACC_W-1:0] step;
        logic signed [ACC_W-1:0] final_value;
        logic signed [ACC_W-1:0] divisor;
        logic signed [ACC_W:0]   wide_sum;
        group_result_t           r;
        op_t                     op;
        xw = ACC_W'(x);
        op = (op_setting > OP_MEAN) ? OP_SUM : op_t'(op_setting);
        if (opening)
        begin
            running_acc = xw;
            group_count = 1;
            clamped = 1'b0;
            opening = 1'b0;
        end
        else
        begin
            case (op)
                OP_MAX:
                begin
                    if (xw > running_acc)
                    begin
                        running_acc = xw;
                    end
                end
                OP_MIN:
                begin
                    if (xw < running_acc)
                    begin
                        running_acc = xw;
                    end
                end
                OP_PROD:
                begin
                    if (out_of_q16(running_acc))
                    begin
                        clamped = 1'b1;
                    end
                    factor = clamp_q16(running_acc);
                    step = (factor * xw) >>> PROD_SHIFT;
                    if (out_of_q16(step))
                    begin
                        clamped = 1'b1;
                    end
                    running_acc = clamp_q16(step);
                end
                default:
                begin
                    wide_sum = {running_acc[ACC_W-1], running_acc} + {xw[ACC_W-1], xw};
                    if (wide_sum[ACC_W] != wide_sum[ACC_W-1])
                    begin
                        running_acc = wide_sum[ACC_W] ? ACC_MIN : ACC_MAX;
                        clamped = 1'b1;
                    end
                    else
                    begin
                        running_acc = wide_sum[ACC_W-1:0];
                    end
                end
            endcase
            if (group_count < COUNT_CEIL)
            begin
                group_count++;
            end
        end

        if (closes)
        begin
            divisor = ACC_W'(group_count);
            final_value = (op == OP_MEAN) ? running_acc / divisor : running_acc;
            step = clamp_q16(final_value);
            r.value = step[DATA_W-1:0];
            r.total = group_count[TOTAL_W-1:0];
            r.sat = clamped | out_of_q16(final_value);
            pending_results.push_back(r);
            running_acc = '0;
            group_count = 0;
            clamped = 1'b0;
            opening = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_setting = OP_RESET;
            running_acc = '0;
            group_count = 0;
            opening = 1'b1;
            clamped = 1'b0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                op_setting = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with no closed group", 64'(reduced_value), '0);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (reduced_value !== oldest.value)
                    begin
                        report_mismatch("reduced_value", 64'(reduced_value),
                                        64'(oldest.value));
                    end
                    if (element_total !== oldest.total)
                    begin
                        report_mismatch("element_total", 64'(element_total),
                                        64'(oldest.total));
                    end
                    if (saturated !== oldest.sat)
                    begin
                        report_mismatch("saturated", 64'(saturated), 64'(oldest.sat));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                reduce_element(element_value, last_of_group);
            end
        end
        mismatches <= errors;
        outstanding <= pending_results.size();
    end

endmodule

// File: test/vector_reduction_unit_top_test.sv
`timescale 1ns / 1ps

module vector_reduction_unit_top_test;
    import vru_pkg::*;

    localparam int COUNT_BITS     = 24;
    // Settle time before a register write: a full element queue of product
    // steps plus the mean divider, with margin.
    localparam int SETTLE_CYCLES  = 100;
    localparam int TAIL_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SEGMENTS       = 16;
    localparam int SEGMENT_ITEMS  = 90;

    // Codes above the defined operations; the block treats them as sum
    localparam logic [OP_W-1:0] SPARE_CODE_LO = 3'd5;
    localparam logic [OP_W-1:0] SPARE_CODE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] ONE_Q16  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] HALF_Q16 = 32'sd32768;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [OP_W-1:0]           cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [DATA_W-1:0]  element_value;
    logic                      last_of_group;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [DATA_W-1:0]  reduced_value;
    logic [TOTAL_W-1:0]        element_total;
    logic                      saturated;

    int mismatches;
    int outstanding;

    // Idle / stall odds in percent, changed per stimulus segment
    int in_idle_pct;
    int out_stall_pct;
    int quiet_cycles = 0;

    int              segment;
    int              sent;
    int              group_len;
    int              k;
    logic [OP_W-1:0] seg_code;

    vector_reduction_unit_top #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .element_value(element_value),
        .last_of_group(last_of_group),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .reduced_value(reduced_value),
        .element_total(element_total),
        .saturated    (saturated)
    );

    // Watches all three channels, predicts each group's result and compares
    vector_reduction_unit_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .element_value(element_value),
        .last_of_group(last_of_group),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .reduced_value(reduced_value),
        .element_total(element_total),
        .saturated    (saturated),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver back-pressure: one fresh draw per cycle
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog: too long without any transaction on any channel means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Half small values in -4.0..4.0 so products stay in range for a few
    // steps, some extremes, and full-width words to toggle every bit.
    function automatic logic signed [DATA_W-1:0] random_element();
        int pick;
        int near_one;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            case ($urandom_range(5))
                0:       return Q32_MAX;
                1:       return Q32_MIN;
                2:       return '0;
                3:       return -32'sd1;
                4:       return ONE_Q16;
                default: return -ONE_Q16;
            endcase
        end
        if (pick <= 5)
        begin
            near_one = $urandom_range(0, 8 * 65536);
            return near_one - 4 * 65536;
        end
        return $urandom;
    endfunction

    // One input transaction; valid stays up until accepted.
    task automatic send_element(input logic signed [DATA_W-1:0] v, input logic closes);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        element_value <= v;
        last_of_group <= closes;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Holds off input until every queued result is out, lets in-flight
    // elements retire, then writes the operation register.
    task automatic set_operation(input logic [OP_W-1:0] code);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= code;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        element_value = '0;
        last_of_group = 1'b0;
        in_idle_pct = 0;
        out_stall_pct = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part ----
        // Register still at its reset value (sum): final clamp sets the flag
        send_element(Q32_MAX, 1'b0);
        send_element(32'sd1, 1'b1);
        // Single-element group
        send_element(Q32_MIN, 1'b1);

        set_operation(OP_MAX);
        send_element(-32'sd5, 1'b0);
        send_element(Q32_MIN, 1'b0);
        send_element(Q32_MAX, 1'b0);
        send_element('0, 1'b1);

        set_operation(OP_MIN);
        send_element(32'sd3, 1'b0);
        send_element(Q32_MAX, 1'b0);
        send_element(Q32_MIN, 1'b1);

        // Product: step clamp, then floor rounding of a negative product
        set_operation(OP_PROD);
        send_element(Q32_MAX, 1'b0);
        send_element(Q32_MAX, 1'b1);
        send_element(-32'sd1, 1'b0);
        send_element(HALF_Q16, 1'b1);

        // Mean: truncation toward zero, and a mean at the top of the range
        set_operation(OP_MEAN);
        send_element(-32'sd7, 1'b0);
        send_element(-32'sd2, 1'b1);
        send_element(Q32_MAX, 1'b0);
        send_element(Q32_MAX, 1'b0);
        send_element(Q32_MAX, 1'b1);

        // Highest unused code acts as sum
        set_operation(SPARE_CODE_HI);
        send_element(ONE_Q16, 1'b0);
        send_element(2 * ONE_Q16, 1'b1);

        // Operation switched inside an open group: the wide sum is clamped
        // when the product step picks it up
        set_operation(OP_SUM);
        send_element(Q32_MAX, 1'b0);
        send_element(Q32_MAX, 1'b0);
        set_operation(OP_PROD);
        send_element(2 * ONE_Q16, 1'b1);

        // ---- Random part ----
        // Each segment has one operation and one idle pattern; groups are
        // mostly short with an occasional long one.
        for (segment = 0; segment < SEGMENTS; segment++)
        begin
            case (segment % 4)
                0:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1:
                begin
                    in_idle_pct = 51;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 51;
                end
                default:
                begin
                    in_idle_pct = 14;
                    out_stall_pct = 14;
                end
            endcase
            case (segment)
                0:       seg_code = OP_MAX;
                1:       seg_code = OP_MIN;
                2:       seg_code = OP_SUM;
                3:       seg_code = OP_PROD;
                4:       seg_code = OP_MEAN;
                5:       seg_code = SPARE_CODE_LO;
                6:       seg_code = SPARE_CODE_HI;
                default: seg_code = OP_W'($urandom_range(7));
            endcase
            set_operation(seg_code);
            sent = 0;
            while (sent < SEGMENT_ITEMS)
            begin
                group_len = ($urandom_range(9) < 7) ? $urandom_range(1, 6)
                                                    : $urandom_range(7, 40);
                for (k = 0; k < group_len; k++)
                begin
                    send_element(random_element(), k == group_len - 1);
                end
                sent += group_len;
            end
        end

        // ---- Drain and verdict ----
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
